[src/gmk_pkg.sv]
// gmk_pkg: shared types and constants for the gradient magnitude / orientation block
// depends on nothing
package gmk_pkg;

	localparam int CAND_DEPTH = 4096;
	localparam int CAND_AW    = $clog2(CAND_DEPTH);
	localparam int FILL_W     = CAND_AW + 1;
	localparam int MAG_W      = 16;
	localparam int FRAC_BITS  = 7;
	localparam int CORDIC_N   = 28;
	localparam int ANGLE_BITS = 16;
	localparam logic [7:0] MARK_VALUE = 8'd255;
	localparam logic [MAG_W-1:0] MIN_RESET = MAG_W'(255 << FRAC_BITS);

	typedef enum logic [1:0] {ST_RUN, ST_WAIT, ST_SCAN, ST_DONE} gmk_state_t;

	typedef struct packed {
		logic [MAG_W-1:0] magnitude;
		logic [15:0]      orientation;
		logic             interior;
		logic             cand;
		logic             frame_end;
	} gmk_res_t;

	function automatic logic signed [36:0] atan_val(input int i);
		unique case (i)
			0: atan_val = 37'sd536870912;
			1: atan_val = 37'sd316933406;
			2: atan_val = 37'sd167458907;
			3: atan_val = 37'sd85004756;
			4: atan_val = 37'sd42667331;
			5: atan_val = 37'sd21354465;
			6: atan_val = 37'sd10679838;
			7: atan_val = 37'sd5340245;
			8: atan_val = 37'sd2670163;
			9: atan_val = 37'sd1335087;
			10: atan_val = 37'sd667544;
			11: atan_val = 37'sd333772;
			12: atan_val = 37'sd166886;
			13: atan_val = 37'sd83443;
			14: atan_val = 37'sd41722;
			15: atan_val = 37'sd20861;
			16: atan_val = 37'sd10430;
			17: atan_val = 37'sd5215;
			18: atan_val = 37'sd2608;
			19: atan_val = 37'sd1304;
			20: atan_val = 37'sd652;
			21: atan_val = 37'sd326;
			22: atan_val = 37'sd163;
			23: atan_val = 37'sd81;
			24: atan_val = 37'sd41;
			25: atan_val = 37'sd20;
			26: atan_val = 37'sd10;
			default: atan_val = 37'sd5;
		endcase
	endfunction

endpackage

[src/gmk_grad.sv]
// gmk_grad: iterative magnitude (bit-serial square root) and angle (vectoring cordic)
// depends on gmk_pkg
module gmk_grad import gmk_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic signed [8:0] dx,
	input  logic signed [8:0] dy,
	input  logic             interior,
	input  logic             cand,
	input  logic             frame_end,
	output logic             busy,
	output logic             done,
	output gmk_res_t         res
);
	localparam int SQ_W = 17 + 2*FRAC_BITS;
	localparam int R_W  = SQ_W;
	localparam int XW   = 37;

	logic signed [XW-1:0] x_q, y_q, z_q;
	logic [SQ_W-1:0] v_q, b_q;
	logic [R_W-1:0]  r_q;
	logic [4:0]      it_q;
	logic            run_q, zero_q, int_q, cand_q, fe_q;
	logic [SQ_W-1:0] sq_in;
	logic signed [XW-1:0] ys, xs, zr;
	logic [SQ_W-1:0] rb;
	logic [R_W-1:0]  rr;
	logic signed [XW-1:0] x0, y0;

	assign sq_in = SQ_W'(($signed(dx) * $signed(dx)) + ($signed(dy) * $signed(dy))) << (2*FRAC_BITS);
	assign ys = y_q >>> it_q;
	assign xs = x_q >>> it_q;
	assign rb = SQ_W'(r_q) + b_q;
	assign x0 = XW'(dx) <<< 20;
	assign y0 = XW'(dy) <<< 20;
	assign busy = run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
		end else begin
			done <= !start && run_q && (it_q == 5'(CORDIC_N - 1));
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && it_q == 5'(CORDIC_N - 1)) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			it_q   <= '0;
			zero_q <= (dx == 0) && (dy == 0);
			int_q  <= interior;
			cand_q <= cand;
			fe_q   <= frame_end;
			v_q    <= sq_in;
			b_q    <= SQ_W'(1) << (SQ_W - 1 - ((SQ_W - 1) % 2));
			r_q    <= '0;
			if (dx < 0) begin
				x_q <= -x0;
				y_q <= -y0;
				z_q <= (dy >= 0) ? 37'sh0_8000_0000 : -37'sh0_8000_0000;
			end else begin
				x_q <= x0;
				y_q <= y0;
				z_q <= '0;
			end
		end else if (run_q) begin
			it_q <= it_q + 5'd1;
			if (y_q > 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_val(int'(it_q));
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_val(int'(it_q));
			end
			if (b_q != 0) begin
				if (v_q >= rb) begin
					v_q <= v_q - rb;
					r_q <= R_W'((SQ_W'(r_q) >> 1) + b_q);
				end else begin
					r_q <= r_q >> 1;
				end
				b_q <= b_q >> 2;
			end
		end
	end

	assign zr = (z_q + (XW'(1) <<< (31 - ANGLE_BITS))) >>> (32 - ANGLE_BITS);
	assign rr = (v_q > SQ_W'(r_q)) ? r_q + R_W'(1) : r_q;

	always_comb begin
		res.magnitude   = int_q ? ((rr > R_W'(16'hFFFF)) ? 16'hFFFF : rr[15:0]) : '0;
		res.orientation = (int_q && !zero_q) ? zr[15:0] : '0;
		res.interior    = int_q;
		res.cand        = cand_q;
		res.frame_end   = fe_q;
	end
endmodule

[src/gmk_store.sv]
// gmk_store: candidate magnitude memory, frame statistics and end-of-frame count walk
// depends on gmk_pkg
module gmk_store import gmk_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              done,
	input  gmk_res_t          res,
	output logic              busy,
	output logic              out_load,
	output logic [MAG_W-1:0]  max_out,
	output logic [MAG_W-1:0]  min_out,
	output logic [12:0]       count_out,
	output logic              ovf_out
);
	logic [MAG_W-1:0] mem [CAND_DEPTH];
	logic [MAG_W-1:0] rd_q;
	logic [MAG_W-1:0] max_q, min_q;
	logic [FILL_W-1:0] fill_q, scan_q;
	logic [12:0] cnt_q;
	logic ovf_q, rd_v_q;
	gmk_state_t st_q, st_d;
	logic [MAG_W-1:0] nmax, nmin;
	logic wr_en, scan_rd;

	assign nmax = (res.interior && res.magnitude > max_q) ? res.magnitude : max_q;
	assign nmin = (res.interior && res.magnitude < min_q) ? res.magnitude : min_q;
	assign wr_en = done && res.interior && res.cand && (fill_q != FILL_W'(CAND_DEPTH));
	assign scan_rd = (st_q == ST_SCAN) && (scan_q < fill_q);

	always_ff @(posedge clk) begin
		if (wr_en) mem[fill_q[CAND_AW-1:0]] <= res.magnitude;
		rd_q <= mem[scan_q[CAND_AW-1:0]];
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_RUN:  if (done && res.frame_end) st_d = ST_SCAN;
			ST_SCAN: if (!scan_rd) st_d = ST_WAIT;
			ST_WAIT: if (!rd_v_q) st_d = ST_DONE;
			ST_DONE: st_d = ST_RUN;
			default: st_d = ST_RUN;
		endcase
	end

	assign busy = (st_q != ST_RUN);
	assign out_load = (done && !res.frame_end) || (st_q == ST_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RUN; max_q <= '0; min_q <= MIN_RESET;
			fill_q <= '0; ovf_q <= 1'b0; scan_q <= '0; cnt_q <= '0; rd_v_q <= 1'b0;
			max_out <= '0; min_out <= MIN_RESET; count_out <= '0; ovf_out <= 1'b0;
		end else begin
			st_q <= st_d;
			rd_v_q <= scan_rd;
			if (rd_v_q && ({4'd0, rd_q} * 20'd10 > {4'd0, max_q})) cnt_q <= cnt_q + 13'd1;
			if (scan_rd) scan_q <= scan_q + FILL_W'(1);
			if (done) begin
				max_q <= nmax;
				min_q <= nmin;
				if (wr_en) fill_q <= fill_q + FILL_W'(1);
				if (res.interior && res.cand && !wr_en) ovf_q <= 1'b1;
				max_out <= nmax;
				min_out <= nmin;
				count_out <= '0;
				ovf_out <= ovf_q || (res.interior && res.cand && !wr_en);
				scan_q <= '0;
				cnt_q <= '0;
			end
			if (st_q == ST_DONE) begin
				count_out <= cnt_q;
				max_q <= '0; min_q <= MIN_RESET; fill_q <= '0; ovf_q <= 1'b0;
			end
		end
	end

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(CAND_DEPTH)) else $error("fill beyond depth");
	a_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_RUN) |-> !rd_v_q || $past(st_q) != ST_RUN) else $error("stray read");
	a_nowr: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !done) else $error("item during scan");
endmodule

[src/gradient_mag_ori_keypoint_count_top.sv]
// gradient magnitude, orientation and per-frame keypoint count: top level
// depends on gmk_pkg, gmk_grad, gmk_store
// each pixel is accepted, then iterated by the shared cordic/square-root unit, and its result
// registered; a frame_end word adds a walk over the candidate memory, one memory read per
// cycle. the next word is taken once the result register is free or being emptied.
module gradient_mag_ori_keypoint_count_top import gmk_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // center, right, below, has_right, has_below, extremum
	input  logic        s_tlast,  // frame_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata   // magnitude, orientation, max, min, key_count, overflow
);
	logic busy_g, busy_s, done, load, ov_q;
	gmk_res_t res;
	logic [MAG_W-1:0] mx, mn, mag_q, ori_q;
	logic [12:0] kc;
	logic ovf, acc;
	logic [7:0] c, r, b;

	assign c = s_tdata[7:0];
	assign r = s_tdata[15:8];
	assign b = s_tdata[23:16];
	assign s_tready = !busy_g && !busy_s && !done && !(m_tvalid && !m_tready);
	assign acc = s_tvalid && s_tready;

	gmk_grad u_grad (
		.clk, .arst_n, .start(acc),
		.dx($signed({1'b0, c}) - $signed({1'b0, r})),
		.dy($signed({1'b0, c}) - $signed({1'b0, b})),
		.interior(s_tdata[24] & s_tdata[25]),
		.cand(s_tdata[33:26] == MARK_VALUE),
		.frame_end(s_tlast),
		.busy(busy_g), .done, .res);

	gmk_store u_store (
		.clk, .arst_n, .done, .res, .busy(busy_s), .out_load(load),
		.max_out(mx), .min_out(mn), .count_out(kc), .ovf_out(ovf));

	always_ff @(posedge clk) begin
		if (done) begin
			mag_q <= res.magnitude;
			ori_q <= res.orientation;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (load) ov_q <= 1'b1;
		else if (m_tready) ov_q <= 1'b0;
	end
	assign m_tvalid = ov_q;
	assign m_tdata = {2'd0, ovf, kc, mn, mx, ori_q, mag_q};
endmodule
